[rtl/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg
// Widths and types shared by the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

  // coordinate and edge widths
  localparam int CW  = 32;
  localparam int EW  = CW + 1;
  // signed edge product and signed cross component
  localparam int PRW = 2 * EW;
  localparam int NW  = PRW + 1;
  // cross component magnitude, split in two halves for squaring
  localparam int MW  = NW - 1;
  localparam int HW  = MW / 2;
  // square of a magnitude and sum of three squares
  localparam int SQW = 2 * MW;
  localparam int SW  = SQW + 2;
  // output format
  localparam int NFB = 30;
  localparam int OW  = NFB + 2;
  // root digits: one per step, one step per pipeline stage
  localparam int XW     = NFB + 2;
  localparam int NSTEPS = XW;
  // running product x*s and residual
  localparam int PW = SW + XW;
  localparam int RW = PW + 6;

  // per component state of the digit recurrence
  typedef struct packed {
    logic [RW-1:0] w;
    logic [PW-1:0] p;
    logic [XW-1:0] x;
  } lane_t;

  // one item in flight through the recurrence
  typedef struct packed {
    logic          deg;
    logic [2:0]    neg;
    logic [SW-1:0] s;
    lane_t [2:0]   ln;
  } step_t;

endpackage

[rtl/tun_cross.sv]
// ----------------------------------------------------------------------------
// tun_cross
// Edges, edge products, cross product and component magnitudes (4 stages).
// ----------------------------------------------------------------------------
module tun_cross import tun_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [CW-1:0]  a_x_i,
  input  logic signed [CW-1:0]  a_y_i,
  input  logic signed [CW-1:0]  a_z_i,
  input  logic signed [CW-1:0]  b_x_i,
  input  logic signed [CW-1:0]  b_y_i,
  input  logic signed [CW-1:0]  b_z_i,
  input  logic signed [CW-1:0]  c_x_i,
  input  logic signed [CW-1:0]  c_y_i,
  input  logic signed [CW-1:0]  c_z_i,
  output logic                  valid_o,
  output logic [2:0][MW-1:0]    mag_o,
  output logic [2:0]            neg_o
);

  logic [3:0] vld_q;

  logic signed [EW-1:0]  e1_q [3];
  logic signed [EW-1:0]  e2_q [3];
  logic signed [PRW-1:0] pp_q [3];
  logic signed [PRW-1:0] pr_q [3];
  logic signed [NW-1:0]  n_q  [3];
  logic signed [NW-1:0]  nn   [3];
  logic [2:0][MW-1:0]    mag_q;
  logic [2:0]            neg_q;

  // valid bits follow the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // edges
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e1_q[0] <= EW'(b_x_i) - EW'(a_x_i);
      e1_q[1] <= EW'(b_y_i) - EW'(a_y_i);
      e1_q[2] <= EW'(b_z_i) - EW'(a_z_i);
      e2_q[0] <= EW'(c_x_i) - EW'(a_x_i);
      e2_q[1] <= EW'(c_y_i) - EW'(a_y_i);
      e2_q[2] <= EW'(c_z_i) - EW'(a_z_i);
    end
  end

  // edge products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q[0] <= e2_q[2] * e1_q[1];
      pr_q[0] <= e2_q[1] * e1_q[2];
      pp_q[1] <= e2_q[0] * e1_q[2];
      pr_q[1] <= e2_q[2] * e1_q[0];
      pp_q[2] <= e2_q[1] * e1_q[0];
      pr_q[2] <= e2_q[0] * e1_q[1];
    end
  end

  // cross components
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        n_q[i] <= NW'(pp_q[i]) - NW'(pr_q[i]);
      end
    end
  end

  // sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nn[i] = -n_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= n_q[i][NW-1];
        mag_q[i] <= n_q[i][NW-1] ? nn[i][MW-1:0] : n_q[i][MW-1:0];
      end
    end
  end

  assign valid_o = vld_q[3];
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;

endmodule

[rtl/tun_square.sv]
// ----------------------------------------------------------------------------
// tun_square
// Squares of the magnitudes from half-width products and their sum (3 stages).
// ----------------------------------------------------------------------------
module tun_square import tun_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2:0][MW-1:0] mag_i,
  input  logic [2:0]         neg_i,
  output logic               valid_o,
  output step_t              step_o
);

  logic [2:0] vld_q;

  logic [2*HW-1:0] hh_q [3];
  logic [2*HW-1:0] hl_q [3];
  logic [2*HW-1:0] ll_q [3];
  logic [SQW-1:0]  sq_q [3];
  logic [2:0]      neg1_q, neg2_q;
  step_t           step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // partial products of each magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= neg_i;
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= mag_i[i][MW-1:HW] * mag_i[i][MW-1:HW];
        hl_q[i] <= mag_i[i][MW-1:HW] * mag_i[i][HW-1:0];
        ll_q[i] <= mag_i[i][HW-1:0] * mag_i[i][HW-1:0];
      end
    end
  end

  // full squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg2_q <= neg1_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (SQW'(hh_q[i]) << (2 * HW)) + (SQW'(hl_q[i]) << (HW + 1))
                   + SQW'(ll_q[i]);
      end
    end
  end

  // sum of squares and initial recurrence state
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q.deg <= ~|{sq_q[0], sq_q[1], sq_q[2]};
      step_q.neg <= neg2_q;
      step_q.s   <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      for (int i = 0; i < 3; i++) begin
        step_q.ln[i].w <= RW'(sq_q[i]);
        step_q.ln[i].p <= '0;
        step_q.ln[i].x <= '0;
      end
    end
  end

  assign valid_o = vld_q[2];
  assign step_o  = step_q;

endmodule

[rtl/tun_root_step.sv]
// ----------------------------------------------------------------------------
// tun_root_step
// One digit of x = floor(sqrt(m^2 * 4^(F+1) / s)) for all three components.
// ----------------------------------------------------------------------------
module tun_root_step import tun_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  step_t step_i,
  output logic  valid_o,
  output step_t step_o
);

  logic  vld_q;
  step_t step_q;
  step_t step_d;

  logic [RW-1:0] trial [3];
  logic [2:0]    take;

  // take the digit when 4*x*s + s fits in the residual
  always_comb begin
    step_d = step_i;
    for (int i = 0; i < 3; i++) begin
      trial[i] = (RW'(step_i.ln[i].p) << 2) + RW'(step_i.s);
      take[i]  = (trial[i] <= step_i.ln[i].w);
      step_d.ln[i].w = take[i] ? ((step_i.ln[i].w - trial[i]) << 2)
                               : (step_i.ln[i].w << 2);
      step_d.ln[i].p = (step_i.ln[i].p << 1) + (take[i] ? PW'(step_i.s) : '0);
      step_d.ln[i].x = {step_i.ln[i].x[XW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign valid_o = vld_q;
  assign step_o  = step_q;

endmodule

[rtl/triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle, Q16.16 vertices in, Q1.30 normal out.
// ----------------------------------------------------------------------------
// stages: 4 cross, 3 square/sum, 32 root digit stages, 1 output
// throughput: one item per cycle while the output is not stalled, one digit of the quotient root per stage
// the whole pipeline holds while a result waits and the output is not taken
// reset clears the valid bits only; the block is ready right after reset
module triangle_unit_normal import tun_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [CW-1:0] a_x_i,
  input  logic signed [CW-1:0] a_y_i,
  input  logic signed [CW-1:0] a_z_i,
  input  logic signed [CW-1:0] b_x_i,
  input  logic signed [CW-1:0] b_y_i,
  input  logic signed [CW-1:0] b_z_i,
  input  logic signed [CW-1:0] c_x_i,
  input  logic signed [CW-1:0] c_y_i,
  input  logic signed [CW-1:0] c_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [OW-1:0] normal_x_o,
  output logic signed [OW-1:0] normal_y_o,
  output logic signed [OW-1:0] normal_z_o,
  output logic                 degenerate_o
);

  logic               en;
  logic               cr_valid;
  logic [2:0][MW-1:0] cr_mag;
  logic [2:0]         cr_neg;

  logic  chain_valid [NSTEPS+1];
  step_t chain       [NSTEPS+1];

  logic                 out_valid_q;
  logic [OW-1:0]        nrm_q [3];
  logic                 deg_q;
  logic [XW:0]          rnd   [3];
  logic [OW-1:0]        qmag  [3];
  logic [OW-1:0]        qres  [3];

  // the pipeline moves whenever the output slot is free or being taken
  assign en         = out_ready_i | ~out_valid_q;
  assign in_ready_o = en;

  tun_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .a_z_i   (a_z_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .b_z_i   (b_z_i),
    .c_x_i   (c_x_i),
    .c_y_i   (c_y_i),
    .c_z_i   (c_z_i),
    .valid_o (cr_valid),
    .mag_o   (cr_mag),
    .neg_o   (cr_neg)
  );

  tun_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cr_valid),
    .mag_i   (cr_mag),
    .neg_i   (cr_neg),
    .valid_o (chain_valid[0]),
    .step_o  (chain[0])
  );

  // root digit stages, most significant digit first
  for (genvar g = 0; g < NSTEPS; g++) begin : g_step
    tun_root_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_valid[g]),
      .step_i  (chain[g]),
      .valid_o (chain_valid[g+1]),
      .step_o  (chain[g+1])
    );
  end

  // round: q = (x + 1) / 2, then apply the sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = (XW+1)'(chain[NSTEPS].ln[i].x) + (XW+1)'(1);
      qmag[i] = OW'(rnd[i][XW:1]);
      qres[i] = chain[NSTEPS].neg[i] ? (~qmag[i] + OW'(1)) : qmag[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain_valid[NSTEPS];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_q <= chain[NSTEPS].deg;
      for (int i = 0; i < 3; i++) begin
        nrm_q[i] <= chain[NSTEPS].deg ? '0 : qres[i];
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign normal_x_o   = nrm_q[0];
  assign normal_y_o   = nrm_q[1];
  assign normal_z_o   = nrm_q[2];
  assign degenerate_o = deg_q;

endmodule

[verif/tun_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_checker
// Watches both channels of triangle_unit_normal, predicts the unit normal of
// every accepted triangle with exact wide arithmetic, and compares each
// accepted result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module tun_checker import tun_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic signed [CW-1:0] a_x_i,
  input  logic signed [CW-1:0] a_y_i,
  input  logic signed [CW-1:0] a_z_i,
  input  logic signed [CW-1:0] b_x_i,
  input  logic signed [CW-1:0] b_y_i,
  input  logic signed [CW-1:0] b_z_i,
  input  logic signed [CW-1:0] c_x_i,
  input  logic signed [CW-1:0] c_y_i,
  input  logic signed [CW-1:0] c_z_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic signed [OW-1:0] normal_x_i,
  input  logic signed [OW-1:0] normal_y_i,
  input  logic signed [OW-1:0] normal_z_i,
  input  logic                 degenerate_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  typedef struct packed {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
    logic          deg;
  } normal_t;

  normal_t expected_normals[$];

  // rounded |n| * 2^NFB / length, exact, ties away from zero
  function automatic logic [OW-1:0] scaled_component(logic [255:0] mag, logic [255:0] sum);
    logic [255:0] rhs;
    logic [255:0] lhs;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    rhs = mag << (NFB + 1);
    rhs = rhs * rhs;
    lo = 0;
    hi = 64'd1 << NFB;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      lhs = 256'(2 * mid - 1);
      lhs = lhs * lhs * sum;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[OW-1:0];
  endfunction

  function automatic normal_t unit_normal(logic signed [CW-1:0] ax, logic signed [CW-1:0] ay,
                                          logic signed [CW-1:0] az, logic signed [CW-1:0] bx,
                                          logic signed [CW-1:0] by, logic signed [CW-1:0] bz,
                                          logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                                          logic signed [CW-1:0] cz);
    logic signed [CW:0]  e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [66:0]  cr [3];
    logic [66:0]         ab;
    logic [255:0]        mag [3];
    logic [255:0]        sum;
    logic [OW-1:0]       q;
    normal_t             r;
    e1x = $signed({bx[CW-1], bx}) - $signed({ax[CW-1], ax});
    e1y = $signed({by[CW-1], by}) - $signed({ay[CW-1], ay});
    e1z = $signed({bz[CW-1], bz}) - $signed({az[CW-1], az});
    e2x = $signed({cx[CW-1], cx}) - $signed({ax[CW-1], ax});
    e2y = $signed({cy[CW-1], cy}) - $signed({ay[CW-1], ay});
    e2z = $signed({cz[CW-1], cz}) - $signed({az[CW-1], az});
    cr[0] = e2z * e1y - e2y * e1z;
    cr[1] = e2x * e1z - e2z * e1x;
    cr[2] = e2y * e1x - e2x * e1y;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      ab = cr[i][66] ? -cr[i] : cr[i];
      mag[i] = 256'(ab);
      sum = sum + mag[i] * mag[i];
    end
    r = '0;
    if (sum == 0) begin
      r.deg = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      q = scaled_component(mag[i], sum);
      if (cr[i][66]) q = -q;
      if (i == 0) r.nx = q;
      else if (i == 1) r.ny = q;
      else r.nz = q;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [OW-1:0] got, logic [OW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // predict on input item, compare on result item
  always @(posedge clk_i) begin
    normal_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_normals.push_back(unit_normal(a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i,
                                               c_x_i, c_y_i, c_z_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_normals.size() == 0) begin
          $display("unexpected result item at %0t", $realtime);
          fail_count_o++;
        end else begin
          want = expected_normals.pop_front();
          if (normal_x_i !== want.nx) report_mismatch("normal_x", normal_x_i, want.nx);
          if (normal_y_i !== want.ny) report_mismatch("normal_y", normal_y_i, want.ny);
          if (normal_z_i !== want.nz) report_mismatch("normal_z", normal_z_i, want.nz);
          if (degenerate_i !== want.deg) begin
            report_mismatch("degenerate", OW'(degenerate_i), OW'(want.deg));
          end
        end
      end
      pending_o <= expected_normals.size();
    end
  end

endmodule

[verif/tb_triangle_unit_normal.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal
// Drives triangles into triangle_unit_normal under several idle and stall
// patterns: directed corner triangles first, then random, collinear and
// small-coordinate ones. Checking is done by tun_checker.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal;
  import tun_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_ITEMS = 1830;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic signed [CW-1:0] a_x_i = '0, a_y_i = '0, a_z_i = '0;
  logic signed [CW-1:0] b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic signed [CW-1:0] c_x_i = '0, c_y_i = '0, c_z_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [OW-1:0] normal_x_o, normal_y_o, normal_z_o;
  logic                 degenerate_o;
  int                   pending;
  int                   fail_count;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  longint               cycles = 0;

  typedef logic [8:0][CW-1:0] triangle_t;

  triangle_unit_normal dut (.*);

  tun_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i, .c_x_i, .c_y_i, .c_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .normal_x_i(normal_x_o), .normal_y_i(normal_y_o), .normal_z_i(normal_z_o),
    .degenerate_i(degenerate_o), .pending_o(pending), .fail_count_o(fail_count)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls and timeout
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("** triangle_unit_normal: FAILED **");
      $finish;
    end
  end

  // one item, with optional idle cycles ahead of it
  task automatic send_triangle(triangle_t t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    {c_z_i, c_y_i, c_x_i, b_z_i, b_y_i, b_x_i, a_z_i, a_y_i, a_x_i} <= t;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic triangle_t random_triangle();
    triangle_t t;
    int        kind;
    int        k;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) t[i] = $urandom();
    if (kind < 3) begin
      // small coordinates near the origin
      for (int i = 0; i < 9; i++) t[i] = $signed($urandom_range(65536 * 8)) - 65536 * 4;
    end else if (kind == 3) begin
      // collinear: c = a + k*(b - a)
      k = $urandom_range(4) - 2;
      for (int i = 0; i < 3; i++) begin
        t[i] = $signed($urandom_range(2000000)) - 1000000;
        t[3 + i] = $signed($urandom_range(2000000)) - 1000000;
        t[6 + i] = t[i] + k * (t[3 + i] - t[i]);
      end
    end else if (kind == 4) begin
      // coincident vertices or an edge of zero length
      t[3 +: 3] = t[0 +: 3];
      if ($urandom_range(1)) t[6 +: 3] = t[0 +: 3];
    end else if (kind == 5) begin
      // extremes mixed in
      for (int i = 0; i < 9; i++)
        if ($urandom_range(1)) t[i] = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    end
    return t;
  endfunction

  initial begin
    triangle_t directed [$];
    directed.push_back('0);
    directed.push_back({9{32'h7fffffff}});
    // right triangle in each coordinate plane
    directed.push_back({32'd0, 32'h00010000, 32'd0, 32'd0, 32'd0, 32'h00010000,
                        32'd0, 32'd0, 32'd0});
    directed.push_back({32'h00010000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h00010000,
                        32'd0, 32'd0, 32'd0});
    directed.push_back({32'd0, 32'h00010000, 32'd0, 32'h00010000, 32'd0, 32'd0,
                        32'd0, 32'd0, 32'd0});
    // widest edges in both directions
    directed.push_back({32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h7fffffff, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h7fffffff});
    directed.push_back({32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h80000000});
    directed.push_back({32'h7fffffff, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h80000000});
    // smallest nonzero cross product, diagonal normal
    directed.push_back({32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0});
    directed.push_back({32'd1, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0});
    directed.push_back({32'hffffffff, 32'd1, 32'd1, 32'd1, 32'hffffffff, 32'd1,
                        32'd0, 32'd0, 32'd0});
    // collinear and coincident
    directed.push_back({32'd6, 32'd4, 32'd2, 32'd3, 32'd2, 32'd1, 32'd0, 32'd0, 32'd0});
    directed.push_back({9{32'h80000000}});
    directed.push_back({32'h12345678, 32'h9abcdef0, 32'h0, 32'h12345678, 32'h9abcdef0,
                        32'h0, 32'h0fedcba9, 32'h87654321, 32'h55555555});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_triangle(directed[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case (n * 5 / RANDOM_ITEMS)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        3: begin idle_pct = 9;  stall_pct = 9;  end
        default: begin idle_pct = $urandom_range(1) * 30; stall_pct = 0; end
      endcase
      // hold the sender until the pipeline drains
      if (n == RANDOM_ITEMS / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      send_triangle(random_triangle());
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("** triangle_unit_normal: PASSED **");
    else $display("** triangle_unit_normal: FAILED **");
    $finish;
  end

endmodule
